### rtl/rvq_pkg.sv
// Shared types, constants and the arctangent table function for the
// rotation-vector-to-quaternion pipeline. No dependencies.
package rvq_pkg;

  localparam int CORDIC_STAGES_DEF = 24;
  localparam int DATA_W  = 24;
  localparam int ROOT_W  = 32;
  localparam int RATIO_W = 31;
  localparam int CW      = 34;

  localparam logic signed [CW-1:0] PI_Q29         = 34'sd1686629713;
  localparam logic signed [CW-1:0] HALF_PI_Q29    = 34'sd843314857;
  localparam logic signed [CW-1:0] QUARTER_PI_Q29 = 34'sd421657428;
  localparam logic signed [CW-1:0] GAIN_Q30       = 34'sd652032874;
  localparam logic [25:0]          ONE_Q22        = 26'd4194304;

  typedef struct packed {
    logic [2:0]                   neg;
    logic [2:0][DATA_W-1:0]       mag;
  } sqrt_side_t;

  typedef struct packed {
    logic                         bypass;
    logic                         ysign;
    logic [31:0]                  ymag;
    logic signed [DATA_W-1:0]     w;
    logic [2:0]                   neg;
  } div_side_t;

  // Restoring long division, only ever evaluated on constants.
  function automatic longint unsigned const_div(input longint unsigned num,
                                                input longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r    = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in Q.29 from the alternating series in Q.62, rounded.
  function automatic logic signed [31:0] atan_q29(input int i);
    longint acc;
    longint term;
    logic   neg;
    acc = 0;
    neg = 1'b0;
    if (i == 0) begin
      return QUARTER_PI_Q29[31:0];
    end
    for (int m = 1; m <= 62; m += 2) begin
      if (i * m <= 62) begin
        term = longint'(const_div(64'(longint'(1) << (62 - i * m)), 64'(m)));
        acc  = neg ? acc - term : acc + term;
        neg  = !neg;
      end
    end
    return 32'((acc + (longint'(1) << 32)) >>> 33);
  endfunction

endpackage

### rtl/rotation_vector_to_quaternion.sv
// Rotation vector to unit quaternion, fully pipelined.
// Depends on rvq_pkg, rvq_isqrt and rvq_div.
//
// Usage: a request on the s_axis channel carries one rotation vector (three
// signed Q3.20 components, radians). For every request the block returns one
// unit quaternion (w, x, y, z, signed Q1.22) on the m_axis channel, in order.
// The cfg channel writes the 12-bit small-angle threshold; it is always ready
// and should only be written while no request is in flight.
//
// The path is: squares and their sum, a 32-stage square root, range reduction,
// one CORDIC stage per iteration, a 31-stage divider for the axis ratios, then
// a multiply and a rounding stage. Throughput is one request per cycle while
// the skid register is empty: every stage holds its own valid bit.
//
// Reset clears all valid bits and sets the threshold to 1. When the receiver
// stalls, a finished result parks in a skid register behind the output
// register; only when that skid register is also full does s_axis_tready drop
// and the whole pipeline hold, so no request is lost or repeated.
module rotation_vector_to_quaternion #(
  parameter int CORDIC_STAGES = rvq_pkg::CORDIC_STAGES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // s_axis_tdata: rot_x [23:0], rot_y [47:24], rot_z [71:48]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,
  // m_axis_tdata: quat_w [23:0], quat_x [47:24], quat_y [71:48], quat_z [95:72]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,
  // Small-angle threshold write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [11:0] cfg_data
);
  import rvq_pkg::*;

  logic adv;
  logic [11:0] thr;

  // The threshold register; writes are taken at any time.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= 12'd1;
    end else if (cfg_valid) begin
      thr <= cfg_data;
    end
  end

  // Stage 0: input capture.
  logic                     v0;
  logic signed [DATA_W-1:0] rin [3];
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= s_axis_tvalid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      rin[0] <= s_axis_tdata[23:0];
      rin[1] <= s_axis_tdata[47:24];
      rin[2] <= s_axis_tdata[71:48];
    end
  end

  // Stage 1: squares, magnitudes and signs.
  logic        v1;
  logic [46:0] sq [3];
  sqrt_side_t  side1;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= v0;
    end
  end
  always_ff @(posedge clk) begin
    logic signed [47:0] p;
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        p = rin[i] * rin[i];
        sq[i]         <= p[46:0];
        side1.neg[i]  <= rin[i][DATA_W-1];
        side1.mag[i]  <= rin[i][DATA_W-1] ? DATA_W'(-rin[i]) : DATA_W'(rin[i]);
      end
    end
  end

  // Stage 2: sum of squares.
  logic        v2;
  logic [47:0] ssum;
  sqrt_side_t  side2;
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      ssum  <= {1'b0, sq[0]} + {1'b0, sq[1]} + {1'b0, sq[2]};
      side2 <= side1;
    end
  end

  // Angle in Q.28, which is the half angle in Q.29.
  logic              vr;
  logic [ROOT_W-1:0] root;
  sqrt_side_t        sider;
  rvq_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (v2),
    .radicand ({ssum, 16'd0}),
    .in_side  (side2),
    .out_valid(vr),
    .root     (root),
    .out_side (sider)
  );

  // Stage 3: small-angle test and first wrap of the half angle.
  logic                 v3;
  logic                 byp3;
  logic signed [CW-1:0] h3;
  logic [ROOT_W-1:0]    root3;
  sqrt_side_t           side3;
  logic signed [CW-1:0] rootx;
  assign rootx = {2'b00, root};
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= vr;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      byp3  <= (root == '0) || (root[31:8] < {12'd0, thr});
      h3    <= (rootx > PI_Q29) ? rootx - (PI_Q29 <<< 1) : rootx;
      root3 <= root;
      side3 <= sider;
    end
  end

  // CORDIC rotation chain; index 0 is the reduced start point.
  logic                 c_v    [CORDIC_STAGES+1];
  logic                 c_byp  [CORDIC_STAGES+1];
  logic                 c_cneg [CORDIC_STAGES+1];
  logic signed [CW-1:0] c_x    [CORDIC_STAGES+1];
  logic signed [CW-1:0] c_y    [CORDIC_STAGES+1];
  logic signed [CW-1:0] c_z    [CORDIC_STAGES+1];
  logic [ROOT_W-1:0]    c_root [CORDIC_STAGES+1];
  sqrt_side_t           c_side [CORDIC_STAGES+1];

  // Stage 4: fold the half angle into [-pi/2, pi/2]; cos changes sign then.
  always_ff @(posedge clk) begin
    if (rst) begin
      c_v[0] <= 1'b0;
    end else if (adv) begin
      c_v[0] <= v3;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      c_byp[0]  <= byp3;
      c_root[0] <= root3;
      c_side[0] <= side3;
      c_x[0]    <= GAIN_Q30;
      c_y[0]    <= '0;
      if (h3 > HALF_PI_Q29) begin
        c_z[0]    <= PI_Q29 - h3;
        c_cneg[0] <= 1'b1;
      end else if (h3 < -HALF_PI_Q29) begin
        c_z[0]    <= -PI_Q29 - h3;
        c_cneg[0] <= 1'b1;
      end else begin
        c_z[0]    <= h3;
        c_cneg[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    localparam logic signed [31:0] ATAN_I = atan_q29(i);
    localparam logic signed [CW-1:0] ATAN_X = CW'(ATAN_I);
    always_ff @(posedge clk) begin
      if (rst) begin
        c_v[i+1] <= 1'b0;
      end else if (adv) begin
        c_v[i+1] <= c_v[i];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        c_byp[i+1]  <= c_byp[i];
        c_cneg[i+1] <= c_cneg[i];
        c_root[i+1] <= c_root[i];
        c_side[i+1] <= c_side[i];
        if (!c_z[i][CW-1]) begin
          c_x[i+1] <= c_x[i] - (c_y[i] >>> i);
          c_y[i+1] <= c_y[i] + (c_x[i] >>> i);
          c_z[i+1] <= c_z[i] - ATAN_X;
        end else begin
          c_x[i+1] <= c_x[i] + (c_y[i] >>> i);
          c_y[i+1] <= c_y[i] - (c_x[i] >>> i);
          c_z[i+1] <= c_z[i] + ATAN_X;
        end
      end
    end
  end

  // Stage 5: scalar part from cos, magnitude and sign of sin.
  logic                 v5;
  div_side_t            dside5;
  logic [2:0][DATA_W-1:0] mag5;
  logic [ROOT_W-1:0]    root5;
  logic signed [CW-1:0] xe, ye;
  logic [CW-1:0]        xm, ym;
  logic [25:0]          wr, ws;
  logic                 wneg;
  assign xe   = c_x[CORDIC_STAGES];
  assign ye   = c_y[CORDIC_STAGES];
  assign xm   = xe[CW-1] ? CW'(-xe) : CW'(xe);
  assign ym   = ye[CW-1] ? CW'(-ye) : CW'(ye);
  assign wr   = 26'((xm + CW'(128)) >> 8);
  assign ws   = (wr > ONE_Q22) ? ONE_Q22 : wr;
  assign wneg = xe[CW-1] ^ c_cneg[CORDIC_STAGES];
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= c_v[CORDIC_STAGES];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      dside5.bypass <= c_byp[CORDIC_STAGES];
      dside5.ysign  <= ye[CW-1];
      dside5.ymag   <= ym[31:0];
      dside5.w      <= wneg ? DATA_W'(-ws) : DATA_W'(ws);
      dside5.neg    <= c_side[CORDIC_STAGES].neg;
      mag5          <= c_side[CORDIC_STAGES].mag;
      root5         <= c_root[CORDIC_STAGES];
    end
  end

  // Axis ratios |v| / angle in Q.30.
  logic                    vd;
  logic [2:0][RATIO_W-1:0] quot;
  div_side_t               dsided;
  rvq_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (v5),
    .mag      (mag5),
    .divisor  (root5),
    .in_side  (dside5),
    .out_valid(vd),
    .quot     (quot),
    .out_side (dsided)
  );

  // Stage 6: |sin| times ratio.
  logic        v6;
  logic [62:0] prod [3];
  div_side_t   dside6;
  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (adv) begin
      v6 <= vd;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        prod[i] <= dsided.ymag * quot[i];
      end
      dside6 <= dsided;
    end
  end

  // Stage 7: round, saturate, sign, identity select.
  logic        t_valid;
  logic [95:0] t_data;
  logic [95:0] t_next;
  always_comb begin
    logic [63:0] rs;
    logic [25:0] r, rsat;
    t_next = '0;
    t_next[23:0] = dside6.w;
    for (int i = 0; i < 3; i++) begin
      rs   = {1'b0, prod[i]} + (64'd1 << 37);
      r    = rs[63:38];
      rsat = (r > ONE_Q22) ? ONE_Q22 : r;
      t_next[24*(i+1) +: 24] = (dside6.ysign != dside6.neg[i]) ? DATA_W'(-rsat)
                                                                : DATA_W'(rsat);
    end
    if (dside6.bypass) begin
      t_next = {72'd0, DATA_W'(ONE_Q22)};
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      t_valid <= 1'b0;
    end else if (adv) begin
      t_valid <= v6;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      t_data <= t_next;
    end
  end

  // Output register with a skid register behind it. The pipeline moves
  // whenever the skid register is empty.
  logic        out_valid, skid_valid;
  logic [95:0] out_data, skid_data;
  assign adv           = !skid_valid;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (m_axis_tready) begin
        skid_valid <= 1'b0;
      end
    end else if (t_valid) begin
      if (!out_valid || m_axis_tready) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid && m_axis_tready) begin
      out_data <= skid_data;
    end else if (!skid_valid && t_valid && (!out_valid || m_axis_tready)) begin
      out_data <= t_data;
    end
    if (!skid_valid && t_valid && out_valid && !m_axis_tready) begin
      skid_data <= t_data;
    end
  end

  // A parked result always has a result in front of it.
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> out_valid)
    else $error("skid register full while output register empty");

  // A finished result that meets a stalled receiver must be parked.
  assert property (@(posedge clk) disable iff (rst)
    (adv && t_valid && out_valid && !m_axis_tready) |=> skid_valid)
    else $error("result dropped during receiver stall");

  // While the pipeline holds, its last stage keeps its result.
  assert property (@(posedge clk) disable iff (rst)
    !adv |=> ($stable(t_valid) && (!t_valid || $stable(t_data))))
    else $error("pipeline tail changed while held");

endmodule

### rtl/rvq_isqrt.sv
// Pipelined integer square root, one root bit per register stage.
// Depends on rvq_pkg for the sideband type.
module rvq_isqrt (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [63:0]         radicand,
  input  rvq_pkg::sqrt_side_t in_side,
  output logic                out_valid,
  output logic [31:0]         root,
  output rvq_pkg::sqrt_side_t out_side
);
  import rvq_pkg::*;

  logic             valid_q [33];
  logic [63:0]      rad_q   [33];
  logic [33:0]      rem_q   [33];
  logic [31:0]      root_q  [33];
  sqrt_side_t       side_q  [33];

  assign valid_q[0] = in_valid;
  assign rad_q[0]   = radicand;
  assign rem_q[0]   = '0;
  assign root_q[0]  = '0;
  assign side_q[0]  = in_side;

  for (genvar k = 0; k < 32; k++) begin : g_stage
    localparam int D = 31 - k;
    logic [35:0] shifted;
    logic [35:0] trial;
    logic        take;

    // Bring down the next two radicand bits and try the next root bit.
    assign shifted = {rem_q[k], rad_q[k][2*D+1 -: 2]};
    assign trial   = {2'b00, root_q[k], 2'b01};
    assign take    = shifted >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[k+1] <= 1'b0;
      end else if (en) begin
        valid_q[k+1] <= valid_q[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_q[k+1]  <= rad_q[k];
        side_q[k+1] <= side_q[k];
        rem_q[k+1]  <= take ? 34'(shifted - trial) : shifted[33:0];
        root_q[k+1] <= {root_q[k][30:0], take};
      end
    end
  end

  assign out_valid = valid_q[32];
  assign root      = root_q[32];
  assign out_side  = side_q[32];

endmodule

### rtl/rvq_div.sv
// Pipelined restoring divider for the three axis ratios |v| * 2^38 / angle,
// one quotient bit per register stage. Depends on rvq_pkg.
module rvq_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic [2:0][rvq_pkg::DATA_W-1:0] mag,
  input  logic [rvq_pkg::ROOT_W-1:0]      divisor,
  input  rvq_pkg::div_side_t              in_side,
  output logic                            out_valid,
  output logic [2:0][rvq_pkg::RATIO_W-1:0] quot,
  output rvq_pkg::div_side_t              out_side
);
  import rvq_pkg::*;

  localparam int NS = RATIO_W;

  logic                     valid_q [NS+1];
  logic [ROOT_W-1:0]        dvs_q   [NS+1];
  logic [2:0][62:0]         rem_q   [NS+1];
  logic [2:0][RATIO_W-1:0]  quot_q  [NS+1];
  div_side_t                side_q  [NS+1];

  assign valid_q[0] = in_valid;
  assign dvs_q[0]   = divisor;
  assign side_q[0]  = in_side;
  assign quot_q[0]  = '0;
  for (genvar i = 0; i < 3; i++) begin : g_init
    assign rem_q[0][i] = {1'b0, mag[i], 38'd0};
  end

  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam int B = NS - 1 - k;
    logic [62:0] dsh;
    logic [2:0]  take;

    assign dsh = {31'd0, dvs_q[k]} << B;
    for (genvar i = 0; i < 3; i++) begin : g_lane
      assign take[i] = rem_q[k][i] >= dsh;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[k+1] <= 1'b0;
      end else if (en) begin
        valid_q[k+1] <= valid_q[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dvs_q[k+1]  <= dvs_q[k];
        side_q[k+1] <= side_q[k];
        for (int i = 0; i < 3; i++) begin
          rem_q[k+1][i]  <= take[i] ? rem_q[k][i] - dsh : rem_q[k][i];
          quot_q[k+1][i] <= {quot_q[k][i][RATIO_W-2:0], take[i]};
        end
      end
    end
  end

  assign out_valid = valid_q[NS];
  assign quot      = quot_q[NS];
  assign out_side  = side_q[NS];

endmodule
